// ===== rtl/ptrmx_pkg.sv =====
package ptrmx_pkg;

  localparam int unsigned KEY_BITS     = 17;
  localparam int unsigned MAX_VERSIONS = 1024;
  localparam int unsigned NODE_POOL    = 32768;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_ROOT,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_HI,
    ST_Q_ROOT,
    ST_Q_CHILD,
    ST_Q_COUNT,
    ST_Q_DECIDE,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_INS_ROOT,
    OP_INS_RD,
    OP_INS_WR,
    OP_Q_HI,
    OP_Q_ROOT,
    OP_Q_CHILD,
    OP_Q_COUNT,
    OP_Q_DECIDE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  bad_range;
    logic  ins_last;
    logic  q_last;
  } dp_stat_t;

endpackage

// ===== rtl/ptrmx_ram.sv =====
module ptrmx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ptrmx_dp.sv =====
module ptrmx_dp #(
  parameter int unsigned KeyBits     = ptrmx_pkg::KEY_BITS,
  parameter int unsigned MaxVersions = ptrmx_pkg::MAX_VERSIONS,
  parameter int unsigned NodePool    = ptrmx_pkg::NODE_POOL
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ptrmx_pkg::dp_cmd_t                 cmd_i,
  output ptrmx_pkg::dp_stat_t                stat_o,
  input  logic [1:0]                         mode_i,
  input  logic [KeyBits-1:0]                 value_i,
  input  logic [$clog2(MaxVersions+1)-1:0]   low_version_i,
  input  logic [$clog2(MaxVersions+1)-1:0]   high_version_i,
  output logic [KeyBits-1:0]                 best_xor_o,
  output logic [$clog2(MaxVersions+1)-1:0]   version_o,
  output logic [1:0]                         status_o
);

  import ptrmx_pkg::*;

  localparam int unsigned NW = $clog2(NodePool);
  localparam int unsigned VW = $clog2(MaxVersions + 1);
  localparam int unsigned LW = $clog2(KeyBits + 1);

  mode_e              mode_q;
  logic [KeyBits-1:0] key_q;
  logic [VW-1:0]      lo_q, hi_q;
  logic [KeyBits-1:0] acc_q;
  status_e            status_q;
  logic [VW-1:0]      vers_q;
  logic [NW-1:0]      nodes_q;
  logic [NW-1:0]      old_q, dst_q, root_q;
  logic [NW-1:0]      u_q, v_q, wu_q, su_q, wv_q, sv_q;
  logic [LW-1:0]      level_q;
  logic [KeyBits-1:0] best_q;
  logic [VW-1:0]      ver_out_q;
  status_e            stat_out_q;

  logic               root_zero_q, ca_zero_q, cb_zero_q, na_zero_q, nb_zero_q;

  logic [VW-1:0]      root_raddr, root_waddr;
  logic [NW-1:0]      root_rdata, root_fix;
  logic               root_we;
  logic [NW-1:0]      ca_raddr, cb_raddr, na_raddr, nb_raddr;
  logic [2*NW-1:0]    ca_rdata, cb_rdata, ca_fix, cb_fix, node_wchild;
  logic [VW-1:0]      na_rdata, nb_rdata, na_fix, nb_fix, node_wcnt;
  logic               node_we;

  logic               side, want, leaf, take, full, bad_range;
  logic [NW-1:0]      nxt_node, new_left, new_right, wu_d, su_d, wv_d, sv_d;
  logic [NW-1:0]      old_left, old_right;

  assign root_fix = root_zero_q ? '0 : root_rdata;
  assign ca_fix   = ca_zero_q ? '0 : ca_rdata;
  assign cb_fix   = cb_zero_q ? '0 : cb_rdata;
  assign na_fix   = na_zero_q ? '0 : na_rdata;
  assign nb_fix   = nb_zero_q ? '0 : nb_rdata;

  assign side     = key_q[KeyBits-1];
  assign want     = ~side;
  assign leaf     = (level_q == LW'(KeyBits));
  assign nxt_node = dst_q + NW'(1);
  assign old_left  = ca_fix[NW-1:0];
  assign old_right = ca_fix[2*NW-1:NW];

  assign full = (vers_q >= VW'(MaxVersions)) ||
                (({1'b0, nodes_q} + (NW+1)'(KeyBits + 1)) > (NW+1)'(NodePool - 1));
  assign bad_range = (lo_q > hi_q) || (hi_q > vers_q);

  assign wu_d = want ? ca_fix[2*NW-1:NW] : ca_fix[NW-1:0];
  assign su_d = want ? ca_fix[NW-1:0]    : ca_fix[2*NW-1:NW];
  assign wv_d = want ? cb_fix[2*NW-1:NW] : cb_fix[NW-1:0];
  assign sv_d = want ? cb_fix[NW-1:0]    : cb_fix[2*NW-1:NW];
  assign take = (nb_fix > na_fix);

  always_comb begin
    root_raddr = lo_q;
    if (cmd_i.op == OP_CHECK && mode_q == MODE_INSERT) begin
      root_raddr = vers_q;
    end else if (cmd_i.op == OP_Q_HI) begin
      root_raddr = hi_q;
    end
  end

  assign root_we    = (cmd_i.op == OP_INS_WR) && leaf;
  assign root_waddr = vers_q + VW'(1);

  assign ca_raddr = (cmd_i.op == OP_INS_RD) ? old_q : u_q;
  assign cb_raddr = v_q;
  assign na_raddr = (cmd_i.op == OP_INS_RD) ? old_q : wu_d;
  assign nb_raddr = wv_d;

  assign new_left    = (!leaf && !side) ? nxt_node : old_left;
  assign new_right   = (!leaf && side)  ? nxt_node : old_right;
  assign node_wchild = {new_right, new_left};
  assign node_wcnt   = na_fix + VW'(1);
  assign node_we     = (cmd_i.op == OP_INS_WR);

  ptrmx_ram #(.Width(NW), .Depth(MaxVersions + 1)) u_root_ram (
    .clk_i   (clk_i),
    .we_i    (root_we),
    .waddr_i (root_waddr),
    .wdata_i (root_q),
    .raddr_i (root_raddr),
    .rdata_o (root_rdata)
  );

  ptrmx_ram #(.Width(2*NW), .Depth(NodePool)) u_child_a_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (dst_q),
    .wdata_i (node_wchild),
    .raddr_i (ca_raddr),
    .rdata_o (ca_rdata)
  );

  ptrmx_ram #(.Width(2*NW), .Depth(NodePool)) u_child_b_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (dst_q),
    .wdata_i (node_wchild),
    .raddr_i (cb_raddr),
    .rdata_o (cb_rdata)
  );

  ptrmx_ram #(.Width(VW), .Depth(NodePool)) u_count_a_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (dst_q),
    .wdata_i (node_wcnt),
    .raddr_i (na_raddr),
    .rdata_o (na_rdata)
  );

  ptrmx_ram #(.Width(VW), .Depth(NodePool)) u_count_b_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (dst_q),
    .wdata_i (node_wcnt),
    .raddr_i (nb_raddr),
    .rdata_o (nb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vers_q  <= '0;
      nodes_q <= '0;
    end else begin
      if (cmd_i.op == OP_CHECK && mode_q == MODE_CLEAR) begin
        vers_q  <= '0;
        nodes_q <= '0;
      end else if (cmd_i.op == OP_INS_WR && leaf) begin
        vers_q  <= vers_q + VW'(1);
        nodes_q <= dst_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    root_zero_q <= (root_raddr == '0);
    ca_zero_q   <= (ca_raddr == '0);
    cb_zero_q   <= (cb_raddr == '0);
    na_zero_q   <= (na_raddr == '0);
    nb_zero_q   <= (nb_raddr == '0);

    unique case (cmd_i.op)
      OP_LOAD: begin
        mode_q   <= mode_e'(mode_i);
        key_q    <= value_i;
        lo_q     <= low_version_i;
        hi_q     <= high_version_i;
        acc_q    <= '0;
        status_q <= STATUS_OK;
      end
      OP_CHECK: begin
        if (mode_q == MODE_INSERT && full) begin
          status_q <= STATUS_FULL;
        end else if (mode_q == MODE_QUERY && bad_range) begin
          status_q <= STATUS_BAD_RANGE;
        end
      end
      OP_INS_ROOT: begin
        old_q   <= root_fix;
        root_q  <= nodes_q + NW'(1);
        dst_q   <= nodes_q + NW'(1);
        level_q <= '0;
      end
      OP_INS_WR: begin
        old_q   <= side ? old_right : old_left;
        dst_q   <= nxt_node;
        key_q   <= key_q << 1;
        level_q <= level_q + LW'(1);
      end
      OP_Q_HI: begin
        u_q <= root_fix;
      end
      OP_Q_ROOT: begin
        v_q     <= root_fix;
        level_q <= '0;
      end
      OP_Q_COUNT: begin
        wu_q <= wu_d;
        su_q <= su_d;
        wv_q <= wv_d;
        sv_q <= sv_d;
      end
      OP_Q_DECIDE: begin
        acc_q   <= (acc_q << 1) | KeyBits'(take);
        u_q     <= take ? wu_q : su_q;
        v_q     <= take ? wv_q : sv_q;
        key_q   <= key_q << 1;
        level_q <= level_q + LW'(1);
      end
      OP_NONE, OP_INS_RD, OP_Q_CHILD: begin
      end
      default: begin
      end
    endcase

    if (cmd_i.res_load) begin
      best_q     <= acc_q;
      ver_out_q  <= vers_q;
      stat_out_q <= status_q;
    end
  end

  assign stat_o.mode      = mode_q;
  assign stat_o.full      = full;
  assign stat_o.bad_range = bad_range;
  assign stat_o.ins_last  = leaf;
  assign stat_o.q_last    = (level_q == LW'(KeyBits - 1));

  assign best_xor_o = best_q;
  assign version_o  = ver_out_q;
  assign status_o   = stat_out_q;

  a_node_write_not_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) node_we |-> (dst_q != '0)
  ) else $error("insert writes over the shared empty node");

  a_versions_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) vers_q <= VW'(MaxVersions)
  ) else $error("version count above capacity");

  a_root_write_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni) root_we |-> (vers_q < VW'(MaxVersions))
  ) else $error("root written with no free version");

endmodule

// ===== rtl/ptrmx_ctrl.sv =====
module ptrmx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ptrmx_pkg::dp_stat_t stat_i,
  output ptrmx_pkg::dp_cmd_t  cmd_o
);

  import ptrmx_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.res_load = 1'b0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.op = OP_CHECK;
        unique case (stat_i.mode)
          MODE_INSERT: state_d = stat_i.full ? ST_FIN : ST_INS_ROOT;
          MODE_QUERY:  state_d = stat_i.bad_range ? ST_FIN : ST_Q_HI;
          MODE_CLEAR, MODE_NONE: state_d = ST_FIN;
          default: state_d = ST_FIN;
        endcase
      end
      ST_INS_ROOT: begin
        cmd_o.op = OP_INS_ROOT;
        state_d  = ST_INS_RD;
      end
      ST_INS_RD: begin
        cmd_o.op = OP_INS_RD;
        state_d  = ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd_o.op = OP_INS_WR;
        state_d  = stat_i.ins_last ? ST_FIN : ST_INS_RD;
      end
      ST_Q_HI: begin
        cmd_o.op = OP_Q_HI;
        state_d  = ST_Q_ROOT;
      end
      ST_Q_ROOT: begin
        cmd_o.op = OP_Q_ROOT;
        state_d  = ST_Q_CHILD;
      end
      ST_Q_CHILD: begin
        cmd_o.op = OP_Q_CHILD;
        state_d  = ST_Q_COUNT;
      end
      ST_Q_COUNT: begin
        cmd_o.op = OP_Q_COUNT;
        state_d  = ST_Q_DECIDE;
      end
      ST_Q_DECIDE: begin
        cmd_o.op = OP_Q_DECIDE;
        state_d  = stat_i.q_last ? ST_FIN : ST_Q_CHILD;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/persistent_trie_range_max_xor_unit.sv =====
// An insert takes a node read and a node write per level before it answers, unless the store is full.
// A query takes a child read, a count read and a compare per bit, unless its range is bad.
// A clear or an unused mode answers straight after its check. One word is worked on at a time; the next
// is taken in the cycle after its result is loaded, later if an earlier result still waits.
// A finished word waits in the output register while the next word is taken in.
// Reset is asynchronous and active low; it empties the store at once, no clearing pass.
module persistent_trie_range_max_xor_unit #(
  parameter int unsigned KeyBits     = ptrmx_pkg::KEY_BITS,
  parameter int unsigned MaxVersions = ptrmx_pkg::MAX_VERSIONS,
  parameter int unsigned NodePool    = ptrmx_pkg::NODE_POOL
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic [KeyBits-1:0]               value_i,
  input  logic [$clog2(MaxVersions+1)-1:0] low_version_i,
  input  logic [$clog2(MaxVersions+1)-1:0] high_version_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [KeyBits-1:0]               best_xor_o,
  output logic [$clog2(MaxVersions+1)-1:0] version_o,
  output logic [1:0]                       status_o
);

  import ptrmx_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptrmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptrmx_dp #(
    .KeyBits     (KeyBits),
    .MaxVersions (MaxVersions),
    .NodePool    (NodePool)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .low_version_i  (low_version_i),
    .high_version_i (high_version_i),
    .best_xor_o     (best_xor_o),
    .version_o      (version_o),
    .status_o       (status_o)
  );

endmodule
